// File: design/mono_framebuffer_draw_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame buffer draw engine
// Shared property wrappers used by the RTL files.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define MFB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain check without reset qualifier
`define MFB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// Types, constants and font table for the frame buffer draw engine.
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int unsigned DefWidth  = 84;
  localparam int unsigned DefHeight = 48;

  localparam logic [3:0] KIND_PIXEL  = 4'd0;
  localparam logic [3:0] KIND_LINE   = 4'd1;
  localparam logic [3:0] KIND_RECT   = 4'd2;
  localparam logic [3:0] KIND_CIRCLE = 4'd3;
  localparam logic [3:0] KIND_GLYPH  = 4'd4;
  localparam logic [3:0] KIND_FILL   = 4'd5;
  localparam logic [3:0] KIND_INVERT = 4'd6;
  localparam logic [3:0] KIND_WRITE  = 4'd7;
  localparam logic [3:0] KIND_READ   = 4'd8;

  localparam logic [6:0] GLYPH_BASE = 7'h20;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  start_x;
    logic [7:0]  start_y;
    logic [7:0]  end_x;
    logic [7:0]  end_y;
    logic [6:0]  circle_radius;
    logic [6:0]  ring_thickness;
    logic        ink;
    logic        filled;
    logic [6:0]  glyph_code;
    logic [8:0]  byte_index;
    logic [7:0]  byte_value;
  } cmd_t;

  // plot request from controller to datapath
  typedef struct packed {
    logic              plot;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic              ink;
  } plot_req_t;

  // buffer operation request
  typedef struct packed {
    logic       clr;   // clear sweep
    logic       fill;  // fill sweep
    logic       inv;   // invert sweep
    logic       wr;
    logic       rd;
    logic [8:0] idx;
    logic [7:0] val;
  } buf_req_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] rdata;
  } dp_status_t;

  function automatic logic [7:0] font_col(input logic [6:0] row, input logic [2:0] col);
    logic [39:0] r;
    case (row)
      7'd0:  r = 40'h0000000000; 7'd1:  r = 40'h00005f0000; 7'd2:  r = 40'h0007000700;
      7'd3:  r = 40'h147f147f14; 7'd4:  r = 40'h242a7f2a12; 7'd5:  r = 40'h2313086462;
      7'd6:  r = 40'h3649552250; 7'd7:  r = 40'h0005030000; 7'd8:  r = 40'h001c224100;
      7'd9:  r = 40'h0041221c00; 7'd10: r = 40'h14083e0814; 7'd11: r = 40'h08083e0808;
      7'd12: r = 40'h0050300000; 7'd13: r = 40'h0808080808; 7'd14: r = 40'h0060600000;
      7'd15: r = 40'h2010080402; 7'd16: r = 40'h3e5149453e; 7'd17: r = 40'h00427f4000;
      7'd18: r = 40'h4261514946; 7'd19: r = 40'h2141454b31; 7'd20: r = 40'h1814127f10;
      7'd21: r = 40'h2745454539; 7'd22: r = 40'h3c4a494930; 7'd23: r = 40'h0171090503;
      7'd24: r = 40'h3649494936; 7'd25: r = 40'h064949291e; 7'd26: r = 40'h0036360000;
      7'd27: r = 40'h0056360000; 7'd28: r = 40'h0814224100; 7'd29: r = 40'h1414141414;
      7'd30: r = 40'h0041221408; 7'd31: r = 40'h0201510906; 7'd32: r = 40'h324979413e;
      7'd33: r = 40'h7e1111117e; 7'd34: r = 40'h7f49494936; 7'd35: r = 40'h3e41414122;
      7'd36: r = 40'h7f4141221c; 7'd37: r = 40'h7f49494941; 7'd38: r = 40'h7f09090901;
      7'd39: r = 40'h3e4149497a; 7'd40: r = 40'h7f0808087f; 7'd41: r = 40'h00417f4100;
      7'd42: r = 40'h2040413f01; 7'd43: r = 40'h7f08142241; 7'd44: r = 40'h7f40404040;
      7'd45: r = 40'h7f020c027f; 7'd46: r = 40'h7f0408107f; 7'd47: r = 40'h3e4141413e;
      7'd48: r = 40'h7f09090906; 7'd49: r = 40'h3e4151215e; 7'd50: r = 40'h7f09192946;
      7'd51: r = 40'h4649494931; 7'd52: r = 40'h01017f0101; 7'd53: r = 40'h3f4040403f;
      7'd54: r = 40'h1f2040201f; 7'd55: r = 40'h3f4038403f; 7'd56: r = 40'h6314081463;
      7'd57: r = 40'h0708700807; 7'd58: r = 40'h6151494543; 7'd59: r = 40'h007f414100;
      7'd60: r = 40'h0204081020; 7'd61: r = 40'h0041417f00; 7'd62: r = 40'h0402010204;
      7'd63: r = 40'h4040404040; 7'd64: r = 40'h0001020400; 7'd65: r = 40'h2054545478;
      7'd66: r = 40'h7f48444438; 7'd67: r = 40'h3844444420; 7'd68: r = 40'h384444487f;
      7'd69: r = 40'h3854545418; 7'd70: r = 40'h087e090102; 7'd71: r = 40'h0c5252523e;
      7'd72: r = 40'h7f08040478; 7'd73: r = 40'h00447d4000; 7'd74: r = 40'h2040443d00;
      7'd75: r = 40'h7f10284400; 7'd76: r = 40'h00417f4000; 7'd77: r = 40'h7c04180478;
      7'd78: r = 40'h7c08040478; 7'd79: r = 40'h3844444438; 7'd80: r = 40'h7c14141408;
      7'd81: r = 40'h081414187c; 7'd82: r = 40'h7c08040408; 7'd83: r = 40'h4854545420;
      7'd84: r = 40'h043f444020; 7'd85: r = 40'h3c4040207c; 7'd86: r = 40'h1c2040201c;
      7'd87: r = 40'h3c4030403c; 7'd88: r = 40'h4428102844; 7'd89: r = 40'h0c5050503c;
      7'd90: r = 40'h4464544c44; 7'd91: r = 40'h0008364100; 7'd92: r = 40'h00007f0000;
      7'd93: r = 40'h0041360800; 7'd94: r = 40'h1008081008; 7'd95: r = 40'h7846414678;
      default: r = 40'h0;
    endcase
    case (col)
      3'd0:    font_col = r[39:32];
      3'd1:    font_col = r[31:24];
      3'd2:    font_col = r[23:16];
      3'd3:    font_col = r[15:8];
      default: font_col = r[7:0];
    endcase
  endfunction

endpackage

// File: design/mono_framebuffer_draw_engine_top.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine_top
// One-bit frame buffer drawing engine: pixel, line, rectangle, circle,
// glyph, fill, invert, byte write and byte read.
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | tuser: kind[3:0]; tdata: command fields, 72 bits
// m_axis  | out | tdata: read_data[7:0]; tuser: done_kind[3:0]
//
// Each plotted pixel is a read-modify-write of one buffer byte through the
// single-port memory. Fill and invert sweep all bytes, reading then writing
// each one. After reset a clearing pass of W*ceil(H/8) bytes runs before
// the first request is taken. One request at a time; the result register
// frees the input side.
module mono_framebuffer_draw_engine_top #(
  parameter int unsigned DISPLAY_WIDTH  = mfb_pkg::DefWidth,
  parameter int unsigned DISPLAY_HEIGHT = mfb_pkg::DefHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_x[7:0] start_y[15:8] end_x[23:16] end_y[31:24]
  // circle_radius[38:32] ring_thickness[45:39] ink[46] filled[47]
  // glyph_code[54:48] byte_index[63:55] byte_value[71:64]
  input  logic [71:0] s_axis_tdata,
  // kind[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0]
  output logic [7:0]  m_axis_tdata,
  // done_kind[3:0]
  output logic [3:0]  m_axis_tuser
);
  import mfb_pkg::*;

  cmd_t cmd_w;
  plot_req_t plot_w;
  buf_req_t buf_w;
  dp_status_t status_w;

  always_comb begin
    cmd_w.kind           = s_axis_tuser;
    cmd_w.start_x        = s_axis_tdata[7:0];
    cmd_w.start_y        = s_axis_tdata[15:8];
    cmd_w.end_x          = s_axis_tdata[23:16];
    cmd_w.end_y          = s_axis_tdata[31:24];
    cmd_w.circle_radius  = s_axis_tdata[38:32];
    cmd_w.ring_thickness = s_axis_tdata[45:39];
    cmd_w.ink            = s_axis_tdata[46];
    cmd_w.filled         = s_axis_tdata[47];
    cmd_w.glyph_code     = s_axis_tdata[54:48];
    cmd_w.byte_index     = s_axis_tdata[63:55];
    cmd_w.byte_value     = s_axis_tdata[71:64];
  end

  mfb_controller u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd_w),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_rdata_o (m_axis_tdata),
    .res_kind_o  (m_axis_tuser),
    .plot_o      (plot_w),
    .buf_o       (buf_w),
    .status_i    (status_w)
  );

  mfb_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .plot_i   (plot_w),
    .buf_i    (buf_w),
    .status_o (status_w)
  );
endmodule

// File: design/mfb_datapath.sv
// ----------------------------------------------------------------------------
// mfb_datapath
// Frame buffer memory with read-modify-write plot path and sweep engine.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_draw_engine_top_defines.svh"
module mfb_datapath #(
  parameter int unsigned DISPLAY_WIDTH  = mfb_pkg::DefWidth,
  parameter int unsigned DISPLAY_HEIGHT = mfb_pkg::DefHeight
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mfb_pkg::plot_req_t    plot_i,
  input  mfb_pkg::buf_req_t     buf_i,
  output mfb_pkg::dp_status_t   status_o
);
  import mfb_pkg::*;

  localparam int unsigned Rows  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int unsigned Bytes = DISPLAY_WIDTH * Rows;
  localparam int unsigned AW    = $clog2(Bytes);

  typedef enum logic [2:0] {
    S_IDLE, S_RMW_RD, S_RMW_WR, S_SWEEP_RD, S_SWEEP_WR, S_RD, S_RD_DATA
  } dp_e;

  typedef enum logic [1:0] {SW_CLR, SW_FILL, SW_INV} sweep_e;

  logic [7:0] mem_q [Bytes];
  dp_e state_q;
  logic [AW-1:0] addr_q;
  logic [2:0] bit_q;
  logic ink_q;
  sweep_e sweep_q;
  logic [7:0] rdata_q, mem_rd_q;
  logic idx_ok_w;

  // address of a plot: y/8 rows times width plus x
  logic inside_w;
  logic [AW-1:0] paddr_w;
  always_comb begin
    inside_w = (plot_i.x >= 0) && (plot_i.x < 12'(DISPLAY_WIDTH)) &&
               (plot_i.y >= 0) && (plot_i.y < 12'(DISPLAY_HEIGHT));
    paddr_w = AW'(plot_i.x[7:0]) + AW'(plot_i.y[7:3]) * AW'(DISPLAY_WIDTH);
  end

  assign idx_ok_w = (32'(buf_i.idx) < Bytes);

  logic [7:0] wdata_w;
  always_comb begin
    wdata_w = mem_rd_q;
    if (state_q == S_RMW_WR) begin
      wdata_w[bit_q] = ink_q;
    end else begin
      case (sweep_q)
        SW_CLR:  wdata_w = 8'h00;
        SW_FILL: wdata_w = 8'hFF;
        default: wdata_w = ~mem_rd_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mem_rd_q <= mem_q[addr_q];
    if (state_q == S_RMW_WR || state_q == S_SWEEP_WR) begin
      mem_q[addr_q] <= wdata_w;
    end
    if (state_q == S_IDLE && buf_i.wr && idx_ok_w) begin
      mem_q[AW'(buf_i.idx)] <= buf_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP_RD;
      addr_q  <= '0;
      bit_q   <= '0;
      ink_q   <= 1'b0;
      sweep_q <= SW_CLR;
      rdata_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (plot_i.plot && inside_w) begin
            addr_q  <= paddr_w;
            bit_q   <= plot_i.y[2:0];
            ink_q   <= plot_i.ink;
            state_q <= S_RMW_RD;
          end else if (buf_i.clr || buf_i.fill || buf_i.inv) begin
            addr_q  <= '0;
            sweep_q <= buf_i.clr ? SW_CLR : (buf_i.fill ? SW_FILL : SW_INV);
            state_q <= S_SWEEP_RD;
          end else if (buf_i.rd) begin
            if (idx_ok_w) begin
              addr_q  <= AW'(buf_i.idx);
              state_q <= S_RD;
            end else begin
              rdata_q <= '0;
            end
          end
        end
        S_RMW_RD:   state_q <= S_RMW_WR;
        S_RMW_WR:   state_q <= S_IDLE;
        S_SWEEP_RD: state_q <= S_SWEEP_WR;
        S_SWEEP_WR: begin
          if (addr_q == AW'(Bytes - 1)) begin
            state_q <= S_IDLE;
          end else begin
            addr_q  <= addr_q + AW'(1);
            state_q <= S_SWEEP_RD;
          end
        end
        S_RD:       state_q <= S_RD_DATA;
        S_RD_DATA: begin
          state_q <= S_IDLE;
          rdata_q <= mem_rd_q;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o.busy  = (state_q != S_IDLE);
  assign status_o.rdata = rdata_q;

  `MFB_ASSERT(a_rmw_seq, clk_i, rst_ni, (state_q == S_RMW_RD) |=> (state_q == S_RMW_WR), "rmw broken")
  `MFB_ASSERT(a_sweep_bound, clk_i, rst_ni, (state_q == S_SWEEP_WR) |-> (addr_q < AW'(Bytes)), "sweep addr")
  `MFB_ASSERT(a_rd_one, clk_i, rst_ni, (state_q == S_RD) |=> (state_q == S_RD_DATA), "read stuck")
endmodule

// File: design/mfb_controller.sv
// ----------------------------------------------------------------------------
// mfb_controller
// Command sequencer: line, rectangle, circle and glyph walks into plots.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_draw_engine_top_defines.svh"
module mfb_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  mfb_pkg::cmd_t        cmd_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [7:0]           res_rdata_o,
  output logic [3:0]           res_kind_o,
  output mfb_pkg::plot_req_t   plot_o,
  output mfb_pkg::buf_req_t    buf_o,
  input  mfb_pkg::dp_status_t  status_i
);
  import mfb_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE, C_DISPATCH, C_LINE_INIT, C_LINE, C_LINE_DONE, C_CIRC_RING, C_CIRC_AX,
    C_CIRC_STEP, C_CIRC_OCT, C_GLYPH, C_WAIT, C_RESULT
  } ctl_e;

  // rectangle segment codes
  localparam logic [2:0] SEG_TOP     = 3'd0;
  localparam logic [2:0] SEG_BOTTOM  = 3'd1;
  localparam logic [2:0] SEG_LEFT    = 3'd2;
  localparam logic [2:0] SEG_FINAL   = 3'd4;
  localparam logic [2:0] SEG_COLUMNS = 3'd5;

  ctl_e state_q, ret_q;
  cmd_t cmd_q;
  logic signed [11:0] x0_q, y0_q, x1_q, y1_q, dx_q, dy_q, err_q;
  logic sxn_q, syn_q, xmaj_q;
  logic [2:0] seg_q;
  logic signed [11:0] colx_q, cnt_q;
  logic signed [11:0] rad_q, f_q, ddy_q, ddx_q, cx_q, cy_q;
  logic [6:0] rings_q;
  logic [2:0] pt_q;
  logic [2:0] gi_q, gj_q;
  logic issued_q;

  logic signed [11:0] sx_w, sy_w, ex_w, ey_w;
  assign sx_w = 12'(signed'(cmd_q.start_x));
  assign sy_w = 12'(signed'(cmd_q.start_y));
  assign ex_w = 12'(signed'(cmd_q.end_x));
  assign ey_w = 12'(signed'(cmd_q.end_y));

  // circle octant point select
  logic signed [11:0] ox_w, oy_w;
  always_comb begin
    case (pt_q)
      3'd0: begin ox_w = cx_q + ddx_q; oy_w = cy_q + f_q; end
      3'd1: begin ox_w = cx_q - ddx_q; oy_w = cy_q + f_q; end
      3'd2: begin ox_w = cx_q + ddx_q; oy_w = cy_q - f_q; end
      3'd3: begin ox_w = cx_q - ddx_q; oy_w = cy_q - f_q; end
      3'd4: begin ox_w = cx_q + f_q; oy_w = cy_q + ddx_q; end
      3'd5: begin ox_w = cx_q - f_q; oy_w = cy_q + ddx_q; end
      3'd6: begin ox_w = cx_q + f_q; oy_w = cy_q - ddx_q; end
      default: begin ox_w = cx_q - f_q; oy_w = cy_q - ddx_q; end
    endcase
  end
  // axis points use rad_q
  logic signed [11:0] ax_w, ay_w;
  always_comb begin
    case (pt_q[1:0])
      2'd0:    begin ax_w = cx_q; ay_w = cy_q + rad_q; end
      2'd1:    begin ax_w = cx_q; ay_w = cy_q - rad_q; end
      2'd2:    begin ax_w = cx_q + rad_q; ay_w = cy_q; end
      default: begin ax_w = cx_q - rad_q; ay_w = cy_q; end
    endcase
  end

  logic [7:0] gcol_w;
  assign gcol_w = font_col(cmd_q.glyph_code - GLYPH_BASE, gi_q);

  // circle bookkeeping reuses registers: ddx_q holds x, f_q holds y, err_q holds f
  logic signed [11:0] abs_dx_w, abs_dy_w;
  assign abs_dx_w = (x1_q < x0_q) ? x0_q - x1_q : x1_q - x0_q;
  assign abs_dy_w = (y1_q < y0_q) ? y0_q - y1_q : y1_q - y0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_WAIT;
      ret_q   <= C_IDLE;
      plot_o  <= '0;
      buf_o   <= '0;
      issued_q <= 1'b1;
      res_valid_o <= 1'b0;
      res_rdata_o <= '0;
      res_kind_o  <= '0;
      cmd_q <= '0;
      {x0_q, y0_q, x1_q, y1_q, dx_q, dy_q, err_q} <= '0;
      {sxn_q, syn_q, xmaj_q, seg_q, colx_q, cnt_q} <= '0;
      {rad_q, f_q, ddy_q, ddx_q, cx_q, cy_q, rings_q, pt_q, gi_q, gj_q} <= '0;
    end else begin
      plot_o.plot <= 1'b0;
      buf_o <= '0;
      issued_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            cmd_q   <= cmd_i;
            state_q <= C_DISPATCH;
          end
        end
        C_DISPATCH: begin
          plot_o.ink <= cmd_q.ink;
          ret_q <= C_RESULT;
          case (cmd_q.kind)
            KIND_PIXEL: begin
              plot_o.plot <= 1'b1; plot_o.x <= sx_w; plot_o.y <= sy_w;
              issued_q <= 1'b1; state_q <= C_WAIT;
            end
            KIND_LINE: begin
              x0_q <= sx_w; y0_q <= sy_w; x1_q <= ex_w; y1_q <= ey_w;
              seg_q <= SEG_FINAL; state_q <= C_LINE_INIT;
            end
            KIND_RECT: begin
              if (cmd_q.filled) begin
                colx_q <= sx_w;
                cnt_q  <= (sx_w > ex_w) ? sx_w - ex_w : ex_w - sx_w;
                seg_q  <= SEG_COLUMNS;
                state_q <= C_LINE_DONE;
              end else begin
                x0_q <= sx_w; y0_q <= sy_w; x1_q <= ex_w; y1_q <= sy_w;
                seg_q <= SEG_TOP; state_q <= C_LINE_INIT;
              end
            end
            KIND_CIRCLE: begin
              cx_q <= sx_w; cy_q <= sy_w;
              rad_q <= 12'(cmd_q.circle_radius);
              rings_q <= cmd_q.ring_thickness;
              state_q <= C_CIRC_RING;
            end
            KIND_GLYPH: begin
              gi_q <= '0; gj_q <= '0;
              state_q <= (cmd_q.glyph_code < GLYPH_BASE) ? C_RESULT : C_GLYPH;
            end
            KIND_FILL: begin
              buf_o.fill <= cmd_q.ink; buf_o.clr <= !cmd_q.ink;
              issued_q <= 1'b1; state_q <= C_WAIT;
            end
            KIND_INVERT: begin
              buf_o.inv <= 1'b1; issued_q <= 1'b1; state_q <= C_WAIT;
            end
            KIND_WRITE: begin
              buf_o.wr <= 1'b1; buf_o.idx <= cmd_q.byte_index;
              buf_o.val <= cmd_q.byte_value; issued_q <= 1'b1; state_q <= C_WAIT;
            end
            KIND_READ: begin
              buf_o.rd <= 1'b1; buf_o.idx <= cmd_q.byte_index;
              issued_q <= 1'b1; state_q <= C_WAIT;
            end
            default: state_q <= C_RESULT;
          endcase
        end
        C_LINE_INIT: begin
          dx_q <= abs_dx_w <<< 1;
          dy_q <= abs_dy_w <<< 1;
          sxn_q <= x1_q < x0_q;
          syn_q <= y1_q < y0_q;
          xmaj_q <= abs_dx_w > abs_dy_w;
          err_q <= (abs_dx_w > abs_dy_w) ? (abs_dy_w <<< 1) - abs_dx_w
                                         : (abs_dx_w <<< 1) - abs_dy_w;
          plot_o.plot <= 1'b1; plot_o.x <= x0_q; plot_o.y <= y0_q;
          issued_q <= 1'b1; ret_q <= C_LINE; state_q <= C_WAIT;
        end
        C_LINE: begin
          if (xmaj_q ? (x0_q == x1_q) : (y0_q == y1_q)) begin
            state_q <= C_LINE_DONE;
          end else begin : step
            logic signed [11:0] nx, ny, ne;
            nx = x0_q; ny = y0_q; ne = err_q;
            if (xmaj_q) begin
              if (err_q >= 0) begin
                ny = syn_q ? y0_q - 12'sd1 : y0_q + 12'sd1; ne = ne - dx_q;
              end
              nx = sxn_q ? x0_q - 12'sd1 : x0_q + 12'sd1;
              ne = ne + dy_q;
            end else begin
              if (err_q >= 0) begin
                nx = sxn_q ? x0_q - 12'sd1 : x0_q + 12'sd1; ne = ne - dy_q;
              end
              ny = syn_q ? y0_q - 12'sd1 : y0_q + 12'sd1;
              ne = ne + dx_q;
            end
            x0_q <= nx; y0_q <= ny; err_q <= ne;
            plot_o.plot <= 1'b1; plot_o.x <= nx; plot_o.y <= ny;
            issued_q <= 1'b1; ret_q <= C_LINE; state_q <= C_WAIT;
          end
        end
        C_LINE_DONE: begin
          // next segment of a rectangle or end of command
          case (seg_q)
            SEG_TOP: begin
              x0_q <= sx_w; y0_q <= ey_w; x1_q <= ex_w; y1_q <= ey_w;
              seg_q <= SEG_BOTTOM; state_q <= C_LINE_INIT;
            end
            SEG_BOTTOM: begin
              x0_q <= sx_w; y0_q <= sy_w; x1_q <= sx_w; y1_q <= ey_w;
              seg_q <= SEG_LEFT; state_q <= C_LINE_INIT;
            end
            SEG_LEFT: begin
              x0_q <= ex_w; y0_q <= sy_w; x1_q <= ex_w; y1_q <= ey_w;
              seg_q <= SEG_FINAL; state_q <= C_LINE_INIT;
            end
            SEG_COLUMNS: begin
              if (cnt_q > 0) begin
                x0_q <= colx_q; y0_q <= sy_w; x1_q <= colx_q; y1_q <= ey_w;
                colx_q <= (sx_w > ex_w) ? colx_q - 12'sd1 : colx_q + 12'sd1;
                cnt_q <= cnt_q - 12'sd1;
                state_q <= C_LINE_INIT;
              end else begin
                state_q <= C_RESULT;
              end
            end
            default: state_q <= C_RESULT;
          endcase
        end
        C_CIRC_RING: begin
          if (rings_q == '0) begin
            state_q <= C_RESULT;
          end else begin
            rings_q <= rings_q - 7'd1;
            err_q <= 12'sd1 - rad_q;
            ddy_q <= -(rad_q <<< 1);
            ddx_q <= '0;
            f_q   <= rad_q;
            dx_q  <= '0;
            pt_q  <= '0;
            state_q <= C_CIRC_AX;
          end
        end
        C_CIRC_AX: begin
          plot_o.plot <= 1'b1; plot_o.x <= ax_w; plot_o.y <= ay_w;
          issued_q <= 1'b1; state_q <= C_WAIT;
          if (pt_q == 3'd3) begin
            pt_q <= '0; ret_q <= C_CIRC_STEP;
          end else begin
            pt_q <= pt_q + 3'd1; ret_q <= C_CIRC_AX;
          end
        end
        C_CIRC_STEP: begin
          // ddx_q is x, f_q is y, err_q is f, dx_q is ddx
          if (ddx_q < f_q) begin : cstep
            logic signed [11:0] ny, nd, nf, ndx;
            ny = f_q; nd = ddy_q; nf = err_q;
            if (err_q >= 0) begin
              ny = f_q - 12'sd1; nd = ddy_q + 12'sd2; nf = nf + nd;
            end
            ndx = dx_q + 12'sd2;
            nf = nf + ndx + 12'sd1;
            f_q <= ny; ddy_q <= nd; err_q <= nf; dx_q <= ndx;
            ddx_q <= ddx_q + 12'sd1;
            pt_q <= '0;
            state_q <= C_CIRC_OCT;
          end else begin
            rad_q <= rad_q - 12'sd1;
            state_q <= C_CIRC_RING;
          end
        end
        C_CIRC_OCT: begin
          plot_o.plot <= 1'b1; plot_o.x <= ox_w; plot_o.y <= oy_w;
          issued_q <= 1'b1; state_q <= C_WAIT;
          if (pt_q == 3'd7) begin
            ret_q <= C_CIRC_STEP;
          end else begin
            pt_q <= pt_q + 3'd1; ret_q <= C_CIRC_OCT;
          end
        end
        C_GLYPH: begin
          plot_o.plot <= 1'b1;
          plot_o.x <= sx_w + 12'(gi_q);
          plot_o.y <= sy_w + 12'(gj_q);
          plot_o.ink <= gcol_w[gj_q] ? cmd_q.ink : !cmd_q.ink;
          issued_q <= 1'b1; state_q <= C_WAIT;
          if (gj_q == 3'd7) begin
            gj_q <= '0;
            gi_q <= gi_q + 3'd1;
            ret_q <= (gi_q == 3'd4) ? C_RESULT : C_GLYPH;
          end else begin
            gj_q <= gj_q + 3'd1; ret_q <= C_GLYPH;
          end
        end
        C_WAIT: begin
          if (!issued_q && !status_i.busy) begin
            state_q <= ret_q;
          end
        end
        C_RESULT: begin
          if (!res_valid_o || res_ready_i) begin
            res_valid_o <= 1'b1;
            res_kind_o  <= cmd_q.kind;
            res_rdata_o <= (cmd_q.kind == KIND_READ) ? status_i.rdata : 8'h00;
            state_q <= C_IDLE;
          end
        end
        default: state_q <= C_IDLE;
      endcase
      if (res_valid_o && res_ready_i && state_q != C_RESULT) begin
        res_valid_o <= 1'b0;
      end
    end
  end

  assign cmd_ready_o = (state_q == C_IDLE);

  `MFB_ASSERT(a_accept_idle, clk_i, rst_ni, (cmd_valid_i && cmd_ready_o) |=> (state_q == C_DISPATCH), "accept")
  `MFB_ASSERT(a_plot_waits, clk_i, rst_ni, plot_o.plot |-> (state_q == C_WAIT), "plot not waited")
  `MFB_ASSERT(a_res_hold, clk_i, rst_ni, (res_valid_o && !res_ready_i) |=> res_valid_o, "result dropped")
endmodule

// File: verif/tb_mono_framebuffer_draw_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_draw_engine_top
// Self-checking bench for the frame buffer draw engine. A local copy of the
// buffer is drawn into for every accepted request; each result is compared
// with the predicted read byte and kind echo. Directed shape cases, random
// requests under three idling mixes and a long output stall are covered.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_draw_engine_top;
  import mfb_pkg::*;

  localparam int W = 84;
  localparam int H = 48;
  localparam int NBYTES = W * ((H + 7) / 8);
  localparam int WATCHDOG_LIMIT = 600000;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] done_kind;
  } result_t;

  // 5x8 font, column 0 in the top byte
  localparam logic [39:0] FONT [96] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
    40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  logic [7:0]  pixel_mem [NBYTES];
  result_t     pending_results [$];
  int          errors = 0;
  int          requests_sent = 0;
  int          results_seen = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  mono_framebuffer_draw_engine_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------- predictor ----------------
  function automatic void plot(int x, int y, bit ink);
    int idx;
    if (x < 0 || x >= W || y < 0 || y >= H) return;
    idx = x + (y / 8) * W;
    pixel_mem[idx][y % 8] = ink;
  endfunction

  function automatic void draw_line(int x0, int y0, int x1, int y1, bit ink);
    int dx, dy, sx, sy, err;
    dy = y1 - y0; dx = x1 - x0; sx = 1; sy = 1;
    if (dy < 0) begin dy = -dy; sy = -1; end
    if (dx < 0) begin dx = -dx; sx = -1; end
    dy *= 2;
    dx *= 2;
    plot(x0, y0, ink);
    if (dx > dy) begin
      err = dy - dx / 2;
      while (x0 != x1) begin
        if (err >= 0) begin y0 += sy; err -= dx; end
        x0 += sx;
        err += dy;
        plot(x0, y0, ink);
      end
    end else begin
      err = dx - dy / 2;
      while (y0 != y1) begin
        if (err >= 0) begin x0 += sx; err -= dy; end
        y0 += sy;
        err += dx;
        plot(x0, y0, ink);
      end
    end
  endfunction

  function automatic void draw_rect(int x0, int y0, int x1, int y1, bit fill, bit ink);
    int n;
    if (fill) begin
      n = (x0 > x1) ? x0 - x1 : x1 - x0;
      while (n > 0) begin
        draw_line(x0, y0, x0, y1, ink);
        if (x0 > x1) x0--; else x0++;
        n--;
      end
    end else begin
      draw_line(x0, y0, x1, y0, ink);
      draw_line(x0, y1, x1, y1, ink);
      draw_line(x0, y0, x0, y1, ink);
      draw_line(x1, y0, x1, y1, ink);
    end
  endfunction

  function automatic void draw_circle(int cx, int cy, int rad, bit ink, int rings);
    int f, ddx, ddy, x, y;
    for (int k = 0; k < rings; k++) begin
      f = 1 - rad; ddx = 0; ddy = -2 * rad; x = 0; y = rad;
      plot(cx, cy + rad, ink);
      plot(cx, cy - rad, ink);
      plot(cx + rad, cy, ink);
      plot(cx - rad, cy, ink);
      while (x < y) begin
        if (f >= 0) begin y--; ddy += 2; f += ddy; end
        x++;
        ddx += 2;
        f += ddx + 1;
        plot(cx + x, cy + y, ink); plot(cx - x, cy + y, ink);
        plot(cx + x, cy - y, ink); plot(cx - x, cy - y, ink);
        plot(cx + y, cy + x, ink); plot(cx - y, cy + x, ink);
        plot(cx + y, cy - x, ink); plot(cx - y, cy - x, ink);
      end
      rad--;
    end
  endfunction

  function automatic void draw_glyph(logic [6:0] code, int x, int y, bit ink);
    logic [7:0] col;
    if (code < GLYPH_BASE) return;
    for (int i = 0; i < 5; i++) begin
      col = FONT[code - GLYPH_BASE][39 - 8 * i -: 8];
      for (int j = 0; j < 8; j++) plot(x + i, y + j, col[j] ? ink : !ink);
    end
  endfunction

  function automatic result_t run_command(cmd_t c);
    result_t r;
    int sx, sy, ex, ey;
    sx = $signed(c.start_x); sy = $signed(c.start_y);
    ex = $signed(c.end_x);   ey = $signed(c.end_y);
    r.read_data = '0;
    r.done_kind = c.kind;
    case (c.kind)
      KIND_PIXEL:  plot(sx, sy, c.ink);
      KIND_LINE:   draw_line(sx, sy, ex, ey, c.ink);
      KIND_RECT:   draw_rect(sx, sy, ex, ey, c.filled, c.ink);
      KIND_CIRCLE: draw_circle(sx, sy, c.circle_radius, c.ink, c.ring_thickness);
      KIND_GLYPH:  draw_glyph(c.glyph_code, sx, sy, c.ink);
      KIND_FILL:   foreach (pixel_mem[i]) pixel_mem[i] = c.ink ? 8'hFF : 8'h00;
      KIND_INVERT: foreach (pixel_mem[i]) pixel_mem[i] = ~pixel_mem[i];
      KIND_WRITE:  if (c.byte_index < NBYTES) pixel_mem[c.byte_index] = c.byte_value;
      KIND_READ:   if (c.byte_index < NBYTES) r.read_data = pixel_mem[c.byte_index];
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic cmd_t make_cmd(logic [3:0] kind, int sx, int sy, int ex, int ey,
                                    int rad, int rings, bit ink, bit fill,
                                    int code, int idx, int val);
    cmd_t c;
    c.kind = kind;
    c.start_x = sx[7:0]; c.start_y = sy[7:0];
    c.end_x = ex[7:0];   c.end_y = ey[7:0];
    c.circle_radius = rad[6:0]; c.ring_thickness = rings[6:0];
    c.ink = ink; c.filled = fill;
    c.glyph_code = code[6:0]; c.byte_index = idx[8:0]; c.byte_value = val[7:0];
    return c;
  endfunction

  task automatic send_request(cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = c.kind;
    s_axis_tdata = {c.byte_value, c.byte_index, c.glyph_code, c.filled, c.ink,
                    c.ring_thickness, c.circle_radius, c.end_y, c.end_x,
                    c.start_y, c.start_x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(run_command(c));
    requests_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic int near_coord();
    if ($urandom_range(9) == 0) return $urandom_range(255);
    return int'($urandom_range(100)) - 8;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int p, sx, ex, rad, rings;
    p = $urandom_range(99);
    sx = near_coord();
    ex = near_coord();
    c = make_cmd(KIND_PIXEL, sx, near_coord(), ex, near_coord(), $urandom_range(20),
                 $urandom_range(5), $urandom_range(1), $urandom_range(1),
                 $urandom_range(127), $urandom_range(511), $urandom_range(255));
    if (p < 10)      c.kind = KIND_PIXEL;
    else if (p < 25) c.kind = KIND_LINE;
    else if (p < 35) begin
      c.kind = KIND_RECT;
      if (c.filled) c.end_x = 8'(int'($signed(c.start_x)) + int'($urandom_range(40)) - 20);
    end else if (p < 45) begin
      c.kind = KIND_CIRCLE;
      rad = $urandom_range(20); rings = $urandom_range(6);
      if ($urandom_range(9) == 0) begin rad = $urandom_range(127); rings = $urandom_range(2); end
      else if ($urandom_range(9) == 0) begin rad = $urandom_range(3); rings = $urandom_range(127); end
      c.circle_radius = rad[6:0]; c.ring_thickness = rings[6:0];
    end else if (p < 55) c.kind = KIND_GLYPH;
    else if (p < 57) begin
      c.kind = KIND_FILL;
      c.ink = ($urandom_range(3) == 0);
    end else if (p < 60) c.kind = KIND_INVERT;
    else if (p < 72) c.kind = KIND_WRITE;
    else if (p < 95) c.kind = KIND_READ;
    else c.kind = 4'($urandom_range(15, 9));
    return c;
  endfunction

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {m_axis_tuser, m_axis_tdata}, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.read_data)
          report_mismatch("read_data", m_axis_tdata, want.read_data);
        if (m_axis_tuser !== want.done_kind)
          report_mismatch("done_kind", m_axis_tuser, want.done_kind);
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_buffer_access();
    send_request(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 32, 0, 0));
    send_request(make_cmd(KIND_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 32, 0, 8'hA5));
    send_request(make_cmd(KIND_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 32, NBYTES - 1, 8'h5A));
    send_request(make_cmd(KIND_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 32, 511, 8'hFF));
    send_request(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 32, NBYTES - 1, 0));
    send_request(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 32, 511, 0));
    send_request(make_cmd(4'd15, 0, 0, 0, 0, 0, 0, 1, 1, 32, 0, 0));
  endtask

  task automatic test_pixels_and_sweeps();
    send_request(make_cmd(KIND_PIXEL, 0, 0, 0, 0, 0, 0, 1, 0, 32, 0, 0));
    send_request(make_cmd(KIND_PIXEL, W - 1, H - 1, 0, 0, 0, 0, 1, 0, 32, 0, 0));
    send_request(make_cmd(KIND_PIXEL, -128, 127, 0, 0, 0, 0, 1, 0, 32, 0, 0));
    send_request(make_cmd(KIND_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 32, 0, 0));
    send_request(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 32, 0, 0));
    send_request(make_cmd(KIND_FILL, 0, 0, 0, 0, 0, 0, 1, 0, 32, 0, 0));
    send_request(make_cmd(KIND_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 32, 0, 0));
  endtask

  task automatic test_shapes();
    send_request(make_cmd(KIND_LINE, -128, -128, 127, 127, 0, 0, 1, 0, 32, 0, 0));
    send_request(make_cmd(KIND_LINE, 80, 2, 3, 40, 0, 0, 1, 0, 32, 0, 0));
    send_request(make_cmd(KIND_RECT, 5, 5, 30, 20, 0, 0, 1, 0, 32, 0, 0));
    send_request(make_cmd(KIND_RECT, 60, 40, 40, 10, 0, 0, 1, 1, 32, 0, 0));
    send_request(make_cmd(KIND_RECT, 10, 0, 10, 47, 0, 0, 1, 1, 32, 0, 0));
    send_request(make_cmd(KIND_CIRCLE, 42, 24, 0, 0, 127, 2, 1, 0, 32, 0, 0));
    send_request(make_cmd(KIND_CIRCLE, 42, 24, 0, 0, 3, 7, 0, 0, 32, 0, 0));
    send_request(make_cmd(KIND_CIRCLE, 20, 20, 0, 0, 10, 0, 1, 0, 32, 0, 0));
    send_request(make_cmd(KIND_GLYPH, 1, 1, 0, 0, 0, 0, 1, 0, 7'h1F, 0, 0));
    send_request(make_cmd(KIND_GLYPH, 1, 1, 0, 0, 0, 0, 1, 0, 7'h20, 0, 0));
    send_request(make_cmd(KIND_GLYPH, W - 3, H - 4, 0, 0, 0, 0, 0, 0, 7'h7F, 0, 0));
    for (int i = 0; i < 8; i++)
      send_request(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 32, i * 60 + 3, 0));
  endtask

  task automatic test_random(int n, int snd_pct, int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    repeat (n) send_request(random_cmd());
  endtask

  task automatic test_output_stall();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    wait_idle();
    hold_cycles = 3000;
    repeat (12) send_request(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 32,
                                      $urandom_range(511), 0));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (pixel_mem[i]) pixel_mem[i] = '0;
    test_buffer_access();
    test_pixels_and_sweeps();
    test_shapes();
    test_random(170, 35, 46);
    test_random(170, 46, 35);
    test_output_stall();
    test_random(170, 0, 0);
    wait_idle();
    repeat (2000) @(posedge clk_i);
    $display("covered %0d requests and %0d results over all draw kinds,", requests_sent,
             results_seen);
    $display("three idling mixes and one long output stall; %0d mismatches", errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
